### sv/dvs_pkg.sv
// ----------------------------------------------------------------------------
// dvs_pkg
// Shared types and constants for the dedup value store: field widths,
// result kind codes and the sequencer states.
// ----------------------------------------------------------------------------
package dvs_pkg;

  localparam int VALUE_W   = 32;
  localparam int COUNT_W   = 7;
  localparam int MAX_DEPTH = 64;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DUMP   = 1'b1;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DUMP,
    ST_FINISH
  } state_e;

endpackage

### sv/dvs_in_if.sv
// ----------------------------------------------------------------------------
// dvs_in_if
// Request channel of the dedup value store: operation mode and value.
// ----------------------------------------------------------------------------
interface dvs_in_if import dvs_pkg::*; ;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);

endinterface

### sv/dvs_out_if.sv
// ----------------------------------------------------------------------------
// dvs_out_if
// Response channel of the dedup value store: insert status or dump entry.
// ----------------------------------------------------------------------------
interface dvs_out_if import dvs_pkg::*; ;

  logic                      valid;
  logic                      ready;
  kind_e                     kind;
  logic                      added;
  logic                      duplicate;
  logic                      dropped_full;
  logic [COUNT_W-1:0]        stored_count;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      last;

  modport source (
    output valid, output kind, output added, output duplicate,
    output dropped_full, output stored_count, output entry_value,
    output last, input ready
  );
  modport sink (
    input valid, input kind, input added, input duplicate,
    input dropped_full, input stored_count, input entry_value,
    input last, output ready
  );

endinterface

### sv/dedup_value_store.sv
// ----------------------------------------------------------------------------
// dedup_value_store
// Set of distinct signed 32-bit values kept in arrival order. Inserts are
// checked against every stored value by one shared comparator; dumps stream
// the stored values oldest first.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+-------------------------------------------
//   req_i   | in  | valid / ready | mode, value
//   rsp_o   | out | valid / ready | kind, added, duplicate, dropped_full,
//           |     |               | stored_count, entry_value, last
//
// An insert compares the value with each stored value, oldest first, and
// registers its result when the scan ends, earlier on a match; the request
// side reopens as the result is registered. A dump gives one entry per cycle
// while the response is taken, after a synchronous read of entry 0. Both are
// set by the single comparator and the single synchronous read port of the
// value memory, walked one entry a cycle. Reset clears the count, sequencer
// and response valid; the memory has no reset and data beyond the count is
// never used. A stalled response holds the sequencer at its last step; the
// request side is ready only when the sequencer is idle.
// ----------------------------------------------------------------------------
module dedup_value_store import dvs_pkg::*; #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dvs_in_if.sink     req_i,
  dvs_out_if.source  rsp_o
);

  // capacity actually used, clamped to between 1 and the memory depth
  localparam int CAP = (MAX_ENTRIES < 1) ? 1 :
                       (MAX_ENTRIES > MAX_DEPTH) ? MAX_DEPTH : MAX_ENTRIES;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CW  = $clog2(CAP + 1);

  // sequencer and counters
  state_e               state_q, state_d;
  logic [AW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        cnt_q, cnt_d;

  // captured request
  logic                      mode_q;
  logic signed [VALUE_W-1:0] value_q;

  // value memory, one read and one write port
  logic [VALUE_W-1:0]   mem_q [CAP];
  logic [VALUE_W-1:0]   rd_data_q;
  logic [AW-1:0]        rd_addr;
  logic                 wr_en;

  // response register
  logic                      out_valid_q;
  kind_e                     kind_q, kind_d;
  logic                      added_q, added_d;
  logic                      dup_q, dup_d;
  logic                      drop_q, drop_d;
  logic [COUNT_W-1:0]        count_q, count_d;
  logic signed [VALUE_W-1:0] entry_q, entry_d;
  logic                      last_q, last_d;
  logic                      out_load;
  logic                      out_free;

  logic                 req_fire;
  logic [CW-1:0]        idx_ext;
  logic                 idx_last;
  logic [AW-1:0]        idx_next;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // position after the entry now in the read register
  assign idx_ext  = CW'(idx_q) + CW'(1);
  assign idx_last = (idx_ext == cnt_q);
  assign idx_next = (idx_ext < CW'(CAP)) ? idx_ext[AW-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  // capture the request payload on acceptance
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      mode_q  <= req_i.mode;
      value_q <= req_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[cnt_q[AW-1:0]] <= value_q;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    rd_addr  = idx_q;
    wr_en    = 1'b0;
    out_load = 1'b0;
    kind_d   = KIND_STATUS;
    added_d  = 1'b0;
    dup_d    = 1'b0;
    drop_d   = 1'b0;
    count_d  = COUNT_W'(cnt_q);
    entry_d  = '0;
    last_d   = 1'b1;

    case (state_q)
      ST_IDLE: begin
        // read entry 0 ahead so the scan starts with data in hand
        rd_addr = '0;
        idx_d   = '0;
        if (req_fire) begin
          if (cnt_q == '0) begin
            state_d = ST_FINISH;
          end else if (req_i.mode == MODE_DUMP) begin
            state_d = ST_DUMP;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_data_q == value_q) begin
          // already stored: report duplicate, hold until the response frees
          if (out_free) begin
            out_load = 1'b1;
            dup_d    = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (idx_last) begin
          state_d = ST_FINISH;
        end else begin
          idx_d   = idx_next;
          rd_addr = idx_next;
        end
      end

      ST_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          kind_d   = KIND_ENTRY;
          entry_d  = rd_data_q;
          last_d   = idx_last;
          if (idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_next;
            rd_addr = idx_next;
          end
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
          if (mode_q == MODE_DUMP) begin
            kind_d  = KIND_EMPTY;
            count_d = '0;
          end else if (cnt_q < CW'(CAP)) begin
            // new value with room: append at the tail
            wr_en   = 1'b1;
            cnt_d   = cnt_q + CW'(1);
            added_d = 1'b1;
            count_d = COUNT_W'(cnt_q + CW'(1));
          end else begin
            drop_d = 1'b1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // response payload, loaded only when the register is free
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      kind_q  <= kind_d;
      added_q <= added_d;
      dup_q   <= dup_d;
      drop_q  <= drop_d;
      count_q <= count_d;
      entry_q <= entry_d;
      last_q  <= last_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.kind         = kind_q;
  assign rsp_o.added        = added_q;
  assign rsp_o.duplicate    = dup_q;
  assign rsp_o.dropped_full = drop_q;
  assign rsp_o.stored_count = count_q;
  assign rsp_o.entry_value  = entry_q;
  assign rsp_o.last         = last_q;

endmodule
